// File: rtl/core/uartrx_pkg.sv
`default_nettype none

package uartrx_pkg;

    localparam int BYTE_W = 8;
    localparam int CNT_W  = 6;

    localparam logic ACT_RX   = 1'b0;
    localparam logic ACT_READ = 1'b1;

    localparam logic STAT_OK      = 1'b0;
    localparam logic STAT_NO_DATA = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_LOAD,
        ST_FLAG
    } t_state;

endpackage

`default_nettype wire

// File: rtl/core/uart_rx_ring_with_error_discard_core.sv
`default_nettype none

// Channel   Dir  Handshake                         Payload
// s_axis    in   i_s_axis_tvalid/o_s_axis_tready   tuser: action; tdata: rx byte, error flags
// m_axis    out  o_m_axis_tvalid/i_m_axis_tready   tuser: status, byte_valid; tdata: byte,
//                                                  count; tlast: last result of a read
//
// A received byte gives no result; the ring is written in the cycle the byte is accepted.
// A read first fetches from the ring memory, then delivers its bytes one after another
// through the single ring memory read port; a read with nothing to deliver gives one result.
// Input tready is low while a read is draining; a stalled output holds the drain in place.
// Reset (synchronous, active low) clears the indexes and the control state; the ring memory
// has no reset and needs no clearing pass.

module uart_rx_ring_with_error_discard_core
    import uartrx_pkg::*;
#(
    parameter int RING_DEPTH = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // [7:0] rx_byte, [8] parity_error, [9] overrun_error, [10] framing_error, [15:11] zero
    input  wire logic [15:0] i_s_axis_tdata,
    // [0] action
    input  wire logic [0:0]  i_s_axis_tuser,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // [7:0] out_byte, [13:8] byte_count, [15:14] zero
    output logic [15:0]      o_m_axis_tdata,
    // [0] status, [1] byte_valid
    output logic [1:0]       o_m_axis_tuser,
    output logic             o_m_axis_tlast
);

    localparam int IW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam logic [IW:0]   DEPTH_V = (IW + 1)'(RING_DEPTH);
    localparam logic [IW-1:0] LAST_IX = IW'(RING_DEPTH - 1);
    localparam logic [IW-1:0] FULL_AT = IW'(RING_DEPTH - 1);

    function automatic logic [IW-1:0] next_ix(input logic [IW-1:0] i);
        logic [IW-1:0] n;
        n = (i == LAST_IX) ? '0 : i + 1'b1;
        return n;
    endfunction

    function automatic logic [IW-1:0] span(input logic [IW-1:0] from, input logic [IW-1:0] to);
        logic [IW:0] s;
        if (to >= from) begin
            s = {1'b0, to} - {1'b0, from};
        end else begin
            s = DEPTH_V - {1'b0, from} + {1'b0, to};
        end
        return s[IW-1:0];
    endfunction

    logic [BYTE_W:0] mem [RING_DEPTH];
    logic [BYTE_W:0] r_rdata;

    t_state          r_state, n_state;
    logic [IW-1:0]   r_widx, r_ridx, r_mark_idx, r_ptr, r_left;
    logic            r_mark_v, r_flag_stat;
    logic [CNT_W-1:0] r_total;

    logic             r_ov, r_o_status, r_o_bv, r_o_last;
    logic [BYTE_W-1:0] r_o_byte;
    logic [CNT_W-1:0]  r_o_cnt;

    logic          in_acc, rx_acc, rd_acc, bad, out_free;
    logic          mem_re, ld_byte, ld_flag;
    logic [IW-1:0] mem_raddr, held, start, cnt;

    assign in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign rx_acc   = in_acc && (i_s_axis_tuser[0] == ACT_RX);
    assign rd_acc   = in_acc && (i_s_axis_tuser[0] == ACT_READ);
    assign bad      = i_s_axis_tdata[8] | i_s_axis_tdata[9] | i_s_axis_tdata[10];
    assign out_free = !r_ov || i_m_axis_tready;
    assign held     = span(r_ridx, r_widx);
    assign start    = r_mark_v ? next_ix(r_mark_idx) : r_ridx;
    assign cnt      = span(start, r_widx);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (rd_acc) begin
                    n_state = (cnt == '0) ? ST_FLAG : ST_FETCH;
                end
            end
            ST_FETCH: n_state = ST_LOAD;
            ST_LOAD: begin
                if (out_free && r_left == IW'(1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_FLAG: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_s_axis_tready = (r_state == ST_IDLE);
        mem_re          = 1'b0;
        mem_raddr       = r_ptr;
        ld_byte         = 1'b0;
        ld_flag         = 1'b0;
        unique case (r_state)
            ST_IDLE: ;
            ST_FETCH: mem_re = 1'b1;
            ST_LOAD: begin
                ld_byte   = out_free;
                mem_re    = out_free && (r_left != IW'(1));
                mem_raddr = next_ix(r_ptr);
            end
            ST_FLAG: ld_flag = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rx_acc && held < FULL_AT) begin
            mem[r_widx] <= bad ? {1'b1, 8'h00} : {1'b0, i_s_axis_tdata[7:0]};
        end
        if (mem_re) begin
            r_rdata <= mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_widx   <= '0;
            r_ridx   <= '0;
            r_mark_v <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (rx_acc && held < FULL_AT) begin
                r_widx <= next_ix(r_widx);
                if (bad) begin
                    r_mark_v   <= 1'b1;
                    r_mark_idx <= r_widx;
                end
            end
            if (rd_acc) begin
                r_ridx      <= r_widx;
                r_mark_v    <= 1'b0;
                r_ptr       <= start;
                r_left      <= cnt;
                r_total     <= CNT_W'(cnt);
                r_flag_stat <= (held == '0) ? STAT_NO_DATA : STAT_OK;
            end
            if (ld_byte) begin
                r_ptr      <= next_ix(r_ptr);
                r_left     <= r_left - 1'b1;
                r_ov       <= 1'b1;
                r_o_status <= STAT_OK;
                r_o_bv     <= 1'b1;
                r_o_byte   <= r_rdata[7:0];
                r_o_last   <= (r_left == IW'(1));
                r_o_cnt    <= (r_left == IW'(1)) ? r_total : '0;
            end else if (ld_flag) begin
                r_ov       <= 1'b1;
                r_o_status <= r_flag_stat;
                r_o_bv     <= 1'b0;
                r_o_byte   <= '0;
                r_o_last   <= 1'b1;
                r_o_cnt    <= '0;
            end else if (i_m_axis_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = {2'b00, r_o_cnt, r_o_byte};
    assign o_m_axis_tuser  = {r_o_bv, r_o_status};
    assign o_m_axis_tlast  = r_o_last;

    a_no_marked_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ld_byte |-> !r_rdata[BYTE_W])
        else $error("marked entry delivered as a byte");

    a_load_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOAD) |-> (r_left != '0))
        else $error("drain running with no entries left");

    a_last_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_o_last && r_o_bv) |-> (r_o_cnt != '0))
        else $error("final byte of a read carries a zero count");

    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |=> (held < FULL_AT || held == FULL_AT))
        else $error("ring holds more than its depth allows");

endmodule

`default_nettype wire

// File: test/testbench.sv
`default_nettype none

module testbench;
    import uartrx_pkg::*;

    localparam int DEPTH          = 64;
    localparam int TARGET_ITEMS   = 410;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic              status;
        logic              byte_valid;
        logic [BYTE_W-1:0] out_byte;
        logic              last;
        logic [CNT_W-1:0]  byte_count;
    } rx_result_t;

    class rx_ring_scoreboard;
        logic [BYTE_W-1:0] ring_data [DEPTH];
        bit                ring_mark [DEPTH];
        int unsigned       wr_idx;
        int unsigned       rd_idx;
        rx_result_t        expected_q [$];
        int                mismatches;
        int                results_seen;
        int                reads_seen;
        int                dropped;
        int                marked;

        function new();
            wr_idx       = 0;
            rd_idx       = 0;
            mismatches   = 0;
            results_seen = 0;
            reads_seen   = 0;
            dropped      = 0;
            marked       = 0;
        endfunction

        function int unsigned held_entries();
            if (rd_idx <= wr_idx) begin
                return wr_idx - rd_idx;
            end
            return DEPTH - rd_idx + wr_idx;
        endfunction

        function int unsigned next_slot(int unsigned i);
            return (i + 1 >= DEPTH) ? 0 : i + 1;
        endfunction

        function void note_item(logic act, logic [BYTE_W-1:0] rx_byte, logic [2:0] flags);
            logic [BYTE_W-1:0] kept [$];
            int unsigned       n;
            logic              fin;
            if (act == ACT_RX) begin
                if (held_entries() < DEPTH - 1) begin
                    ring_mark[wr_idx] = |flags;
                    ring_data[wr_idx] = (|flags) ? 8'h00 : rx_byte;
                    if (|flags) begin
                        marked++;
                    end
                    wr_idx = next_slot(wr_idx);
                end else begin
                    dropped++;
                end
            end else begin
                reads_seen++;
                n = held_entries();
                if (n == 0) begin
                    expected_q.push_back('{STAT_NO_DATA, 1'b0, 8'h00, 1'b1, 6'd0});
                end else begin
                    for (int i = 0; i < n; i++) begin
                        if (ring_mark[rd_idx]) begin
                            kept.delete();
                        end else begin
                            kept.push_back(ring_data[rd_idx]);
                        end
                        rd_idx = next_slot(rd_idx);
                    end
                    if (kept.size() == 0) begin
                        expected_q.push_back('{STAT_OK, 1'b0, 8'h00, 1'b1, 6'd0});
                    end else begin
                        for (int k = 0; k < kept.size(); k++) begin
                            fin = (k == kept.size() - 1);
                            expected_q.push_back('{STAT_OK, 1'b1, kept[k], fin,
                                                   fin ? CNT_W'(kept.size()) : 6'd0});
                        end
                    end
                end
            end
        endfunction

        function void check_result(logic [1:0] user, logic [15:0] data, logic lst);
            rx_result_t want;
            rx_result_t got;
            got = '{user[0], user[1], data[7:0], lst, data[13:8]};
            results_seen++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("unexpected result: status %0d valid %0d byte %02h last %0d count %0d",
                             got.status, got.byte_valid, got.out_byte, got.last, got.byte_count);
                end
            end else begin
                want = expected_q.pop_front();
                if (got.status !== want.status || got.byte_valid !== want.byte_valid ||
                    got.out_byte !== want.out_byte || got.last !== want.last ||
                    got.byte_count !== want.byte_count) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("mismatch at result %0d: status %0d/%0d valid %0d/%0d",
                                 results_seen, want.status, got.status,
                                 want.byte_valid, got.byte_valid);
                        $display("    byte %02h/%02h last %0d/%0d count %0d/%0d (expected/actual)",
                                 want.out_byte, got.out_byte, want.last, got.last,
                                 want.byte_count, got.byte_count);
                    end
                end
            end
        endfunction
    endclass

    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        i_s_axis_tvalid  = 1'b0;
    logic [15:0] i_s_axis_tdata   = '0;
    logic [0:0]  i_s_axis_tuser   = '0;
    logic        i_m_axis_tready  = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [15:0] o_m_axis_tdata;
    logic [1:0]  o_m_axis_tuser;
    logic        o_m_axis_tlast;

    rx_ring_scoreboard board = new();

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int sent_items         = 0;
    int quiet_cycles       = 0;
    logic hold_request     = 1'b0;

    uart_rx_ring_with_error_discard_core #(
        .RING_DEPTH(DEPTH)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            board.check_result(o_m_axis_tuser, o_m_axis_tdata, o_m_axis_tlast);
        end
    end

    always @(negedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", quiet_cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // hold the output for a long stretch on request, otherwise stall at random
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request    <= 1'b0;
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                i_m_axis_tready <= ($urandom_range(99, 0) >= receiver_stall_pct);
            end
        end
    end

    task automatic set_phase(int unsigned p);
        case (p)
            0: begin
                sender_idle_pct    = 0;
                receiver_stall_pct = 0;
            end
            1: begin
                sender_idle_pct    = 77;
                receiver_stall_pct = 0;
            end
            2: begin
                sender_idle_pct    = 0;
                receiver_stall_pct = 77;
            end
            default: begin
                sender_idle_pct    = 6;
                receiver_stall_pct = 6;
            end
        endcase
    endtask

    task automatic send_item(logic act, logic [BYTE_W-1:0] rx_byte, logic [2:0] flags);
        logic took;
        while ($urandom_range(99, 0) < sender_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {5'b0, flags, rx_byte};
        i_s_axis_tuser  <= act;
        do begin
            @(negedge i_clk);
            took = o_s_axis_tready;
            @(posedge i_clk);
        end while (!took);
        board.note_item(act, rx_byte, flags);
        sent_items++;
    endtask

    task automatic send_rx(int unsigned error_pct);
        logic [2:0] flags;
        flags = ($urandom_range(99, 0) < error_pct) ? 3'($urandom_range(7, 1)) : 3'b000;
        send_item(ACT_RX, 8'($urandom_range(255, 0)), flags);
    endtask

    task automatic send_read();
        send_item(ACT_READ, 8'($urandom_range(255, 0)), 3'($urandom_range(7, 0)));
    endtask

    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        while (board.expected_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic run_sequence();
        int unsigned kind;
        int unsigned n;
        kind = $urandom_range(99, 0);
        set_phase($urandom_range(3, 0));
        if (kind < 10) begin
            n = $urandom_range(6, 1);
            repeat (n) begin
                send_item(logic'($urandom_range(1, 0)), 8'($urandom_range(255, 0)),
                          3'($urandom_range(7, 0)));
            end
        end else begin
            n = (kind < 18) ? $urandom_range(70, 55) : $urandom_range(12, 0);
            repeat (n) begin
                send_rx(15);
            end
            if (kind >= 88) begin
                send_item(ACT_RX, 8'($urandom_range(255, 0)), 3'($urandom_range(7, 1)));
            end
            send_read();
            if (kind >= 80 && kind < 85) begin
                send_read();
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_phase(0);
        send_item(ACT_READ, 8'h00, 3'b000);
        send_item(ACT_RX,   8'h00, 3'b000);
        send_item(ACT_RX,   8'hFF, 3'b000);
        send_item(ACT_RX,   8'hA5, 3'b001);
        send_item(ACT_RX,   8'h5A, 3'b000);
        send_item(ACT_READ, 8'hFF, 3'b111);
        send_item(ACT_RX,   8'h3C, 3'b010);
        send_item(ACT_READ, 8'h00, 3'b000);
        send_item(ACT_RX,   8'hFF, 3'b100);
        send_item(ACT_RX,   8'h81, 3'b111);
        send_item(ACT_RX,   8'h00, 3'b000);
        send_item(ACT_RX,   8'h7E, 3'b000);
        send_item(ACT_READ, 8'h5A, 3'b101);
        send_item(ACT_RX,   8'h55, 3'b000);
        send_item(ACT_RX,   8'hAA, 3'b000);
        send_item(ACT_READ, 8'hAA, 3'b010);
        send_item(ACT_READ, 8'h55, 3'b000);
        wait_drained();

        // fill past capacity, then stall the output while the read drains
        repeat (66) begin
            send_rx(0);
        end
        hold_request <= 1'b1;
        send_read();
        repeat (4) begin
            send_rx(20);
        end
        wait_drained();

        while (sent_items < TARGET_ITEMS) begin
            run_sequence();
            if ($urandom_range(9, 0) == 0) begin
                wait_drained();
            end
        end
        set_phase(0);
        send_read();
        wait_drained();
        repeat (16) @(posedge i_clk);

        $display("covered %0d transactions in: %0d reads, %0d results checked",
                 sent_items, board.reads_seen, board.results_seen);
        $display("%0d bytes stored with an error mark, %0d dropped on a full ring",
                 board.marked, board.dropped);
        if (board.mismatches == 0 && board.expected_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
rtl/core/uartrx_pkg.sv
rtl/core/uart_rx_ring_with_error_discard_core.sv
test/testbench.sv
